// ----- rtl/rbi_pkg.sv -----
// shared types and codes of the retransmission buffer index
`timescale 1ns / 1ps
package rbi_pkg;

	localparam int FIFO_DEPTH = 64;
	localparam int FIFO_AW    = 6;

	localparam logic [2:0] FN_STORE    = 3'd0;
	localparam logic [2:0] FN_RTX_SEQ  = 3'd1;
	localparam logic [2:0] FN_RTX_PAIR = 3'd2;
	localparam logic [2:0] FN_ACK      = 3'd3;
	localparam logic [2:0] FN_NACK     = 3'd4;
	localparam logic [2:0] FN_TICK     = 3'd5;
	localparam logic [2:0] FN_QUERY    = 3'd6;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_SKIPPED  = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic [1:0] MODE_CIRC  = 2'd0;
	localparam logic [1:0] MODE_TIMED = 2'd1;

	localparam logic [1:0] CFG_MODE      = 2'd0;
	localparam logic [1:0] CFG_RTX_PT    = 2'd1;
	localparam logic [1:0] CFG_HOLD      = 2'd2;
	localparam logic [1:0] CFG_RTX_START = 2'd3;

	typedef struct packed {
		logic        valid;
		logic [15:0] seq;
		logic        sub;
		logic [15:0] fid;
		logic [15:0] fseq;
		logic        acked;
		logic        nacked;
	} entry_t;

	typedef struct packed {
		logic [15:0] seq;
		logic [31:0] expiry;
	} fifo_rec_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] seq;
		logic        sub;
		logic [15:0] fid;
		logic [15:0] fseq;
		logic [15:0] rtx;
		logic [5:0]  slot;
		logic        newly;
		logic [6:0]  removed;
	} res_t;

endpackage

// ----- rtl/retransmission_buffer_index_unit.sv -----
// top level of the retransmission buffer index
`timescale 1ns / 1ps
// Keeps the index of sent packets in one entry ram of TABLE_DEPTH words and the
// store order in a 64-deep record ram. Every lookup walks the whole entry ram,
// one word a cycle, for an ack, nack, query or retransmit alike. A store takes
// one walk plus one more walk for every order record it pops (in circular mode
// normally one), a tick in timed mode one walk per expired record. After reset
// the entry ram is cleared word by word before the first transfer is taken. A
// finished result waits in the output register while the next item is taken.
module retransmission_buffer_index_unit import rbi_pkg::*; #(
	parameter int TABLE_DEPTH    = 64,
	parameter int CIRCULAR_DEPTH = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// seq_num, payload_type, has_subflow, flow_id, flow_seq
	input  logic [55:0] s_tdata,
	// func
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// seq_num_out, has_subflow_out, flow_id_out, flow_seq_out, rtx_seq_num, slot,
	// newly_acked, removed_count, zero pad
	output logic [79:0] m_tdata,
	// status
	output logic [1:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int AW = $clog2(TABLE_DEPTH);

	typedef enum logic [9:0] {
		S_CLEAR  = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_SCAN   = 10'b0000000100,
		S_LDONE  = 10'b0000001000,
		S_PUSH   = 10'b0000010000,
		S_CIRC   = 10'b0000100000,
		S_TCHK   = 10'b0001000000,
		S_POPRD  = 10'b0010000000,
		S_POPEV  = 10'b0100000000,
		S_FINISH = 10'b1000000000
	} state_t;

	state_t state_q, ret_q;

	logic [1:0]  mode_q;
	logic [6:0]  rtx_pt_q;
	logic [15:0] hold_q;
	logic [15:0] rtx_cnt_q;
	logic [31:0] now_q;
	logic [6:0]  count_q;
	logic [FIFO_AW-1:0] head_q;

	logic [2:0]  func_q;
	logic [15:0] key_q;
	logic [15:0] seq_q, fid_q, fseq_q;
	logic        hs_q;
	logic        pop_q;

	logic [AW:0]   rd_addr_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          seq_hit_q, pair_hit_q, free_hit_q;
	logic [AW-1:0] seq_idx_q, pair_idx_q, free_idx_q;
	entry_t        seq_ent_q, pair_ent_q;

	res_t res_q, out_q;
	logic out_vld_q;

	// entry ram
	logic          e_we;
	logic [AW-1:0] e_waddr;
	entry_t        e_wdata, e_rdata;
	// order ram
	logic               f_we;
	logic [FIFO_AW-1:0] f_waddr;
	fifo_rec_t          f_wdata, f_rdata;
	logic [31:0]        exp_diff;

	// result of a walk
	entry_t        ld_ent;
	logic [AW-1:0] ld_idx;
	logic          ld_hit;

	function automatic res_t status_only(logic [1:0] st);
		res_t r;
		r        = '0;
		r.status = st;
		return r;
	endfunction

	rbi_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_entry_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (rd_addr_q[AW-1:0]),
		.rdata (e_rdata)
	);

	rbi_ram #(.WIDTH($bits(fifo_rec_t)), .DEPTH(FIFO_DEPTH)) u_order_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (head_q),
		.rdata (f_rdata)
	);

	always_comb begin
		ld_ent = seq_ent_q;
		ld_idx = seq_idx_q;
		ld_hit = seq_hit_q;
		case (func_q)
			FN_STORE: begin
				if (!seq_hit_q) begin
					ld_ent       = '0;
					ld_ent.valid = 1'b1;
					ld_ent.seq   = seq_q;
					ld_idx       = free_idx_q;
					ld_hit       = free_hit_q;
				end
				if (hs_q && !ld_ent.sub && !pair_hit_q) begin
					ld_ent.sub  = 1'b1;
					ld_ent.fid  = fid_q;
					ld_ent.fseq = fseq_q;
				end
			end
			FN_ACK:  ld_ent.acked = 1'b1;
			FN_NACK: ld_ent.nacked = 1'b1;
			FN_RTX_PAIR, FN_QUERY: begin
				ld_ent = pair_ent_q;
				ld_idx = pair_idx_q;
				ld_hit = pair_hit_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		e_we    = 1'b0;
		e_waddr = ld_idx;
		e_wdata = ld_ent;
		if (state_q == S_CLEAR) begin
			e_we    = 1'b1;
			e_waddr = rd_addr_q[AW-1:0];
			e_wdata = '0;
		end else if (state_q == S_LDONE) begin
			if (pop_q) begin
				e_we    = seq_hit_q;
				e_waddr = seq_idx_q;
				e_wdata = '0;
			end else begin
				e_we = ld_hit && (func_q == FN_STORE || func_q == FN_ACK ||
					func_q == FN_NACK);
			end
		end
	end

	assign f_we           = (state_q == S_PUSH) && !count_q[6];
	assign f_waddr        = head_q + count_q[FIFO_AW-1:0];
	assign f_wdata.seq    = seq_q;
	assign f_wdata.expiry = now_q + {16'd0, hold_q};
	assign exp_diff       = now_q - f_rdata.expiry;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {1'b0, out_q.removed, out_q.newly, out_q.slot, out_q.rtx, out_q.fseq,
		out_q.fid, out_q.sub, out_q.seq};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			ret_q      <= S_FINISH;
			mode_q     <= MODE_CIRC;
			rtx_pt_q   <= '0;
			hold_q     <= 16'd1000;
			rtx_cnt_q  <= '0;
			now_q      <= '0;
			count_q    <= '0;
			head_q     <= '0;
			rd_addr_q  <= '0;
			rd_vld_s1  <= 1'b0;
			out_vld_q  <= 1'b0;
			pop_q      <= 1'b0;
			seq_hit_q  <= 1'b0;
			pair_hit_q <= 1'b0;
			free_hit_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE:   mode_q <= cfg_data[1:0];
					CFG_RTX_PT: rtx_pt_q <= cfg_data[6:0];
					CFG_HOLD:   hold_q <= cfg_data;
					CFG_RTX_START: rtx_cnt_q <= cfg_data;
					default: ;
				endcase
			end
			// a new result may replace the one leaving in the same cycle
			if (state_q == S_FINISH) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					rd_addr_q <= rd_addr_q + 1'b1;
					if (rd_addr_q == (AW+1)'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						func_q     <= s_tuser;
						seq_q      <= s_tdata[15:0];
						key_q      <= s_tdata[15:0];
						hs_q       <= s_tdata[23];
						fid_q      <= s_tdata[39:24];
						fseq_q     <= s_tdata[55:40];
						pop_q      <= 1'b0;
						rd_addr_q  <= '0;
						rd_vld_s1  <= 1'b0;
						seq_hit_q  <= 1'b0;
						pair_hit_q <= 1'b0;
						free_hit_q <= 1'b0;
						case (s_tuser)
							FN_STORE: begin
								if (s_tdata[22:16] == rtx_pt_q) begin
									res_q   <= status_only(ST_SKIPPED);
									state_q <= S_FINISH;
								end else begin
									res_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							FN_RTX_SEQ, FN_RTX_PAIR, FN_ACK, FN_NACK, FN_QUERY: begin
								res_q   <= '0;
								state_q <= S_SCAN;
							end
							FN_TICK: begin
								res_q <= '0;
								now_q <= now_q + 32'd1;
								ret_q <= S_TCHK;
								state_q <= (mode_q == MODE_TIMED) ? S_TCHK : S_FINISH;
							end
							default: begin
								res_q   <= status_only(ST_NOTFOUND);
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_SCAN: begin
					// one word issued and one word compared per cycle
					if (rd_addr_q < (AW+1)'(TABLE_DEPTH)) begin
						rd_addr_q <= rd_addr_q + 1'b1;
					end
					rd_vld_s1 <= (rd_addr_q < (AW+1)'(TABLE_DEPTH));
					rd_idx_s1 <= rd_addr_q[AW-1:0];
					if (rd_vld_s1) begin
						if (!seq_hit_q && e_rdata.valid && e_rdata.seq == key_q) begin
							seq_hit_q <= 1'b1;
							seq_idx_q <= rd_idx_s1;
							seq_ent_q <= e_rdata;
						end
						if (!pair_hit_q && e_rdata.valid && e_rdata.sub &&
							e_rdata.fid == fid_q && e_rdata.fseq == fseq_q) begin
							pair_hit_q <= 1'b1;
							pair_idx_q <= rd_idx_s1;
							pair_ent_q <= e_rdata;
						end
						if (!free_hit_q && !e_rdata.valid) begin
							free_hit_q <= 1'b1;
							free_idx_q <= rd_idx_s1;
						end
						if (rd_idx_s1 == AW'(TABLE_DEPTH - 1)) begin
							state_q <= S_LDONE;
						end
					end
				end
				S_LDONE: begin
					if (pop_q) begin
						if (seq_hit_q) begin
							res_q.removed <= res_q.removed + 7'd1;
						end
						state_q <= ret_q;
					end else begin
						state_q <= (ld_hit && func_q == FN_STORE &&
							(mode_q == MODE_CIRC || mode_q == MODE_TIMED)) ? S_PUSH : S_FINISH;
						if (!ld_hit) begin
							res_q.status <= (func_q == FN_STORE) ? ST_FULL : ST_NOTFOUND;
						end else begin
							res_q.seq  <= ld_ent.seq;
							res_q.sub  <= ld_ent.sub;
							res_q.fid  <= ld_ent.sub ? ld_ent.fid : 16'd0;
							res_q.fseq <= ld_ent.sub ? ld_ent.fseq : 16'd0;
							res_q.slot <= 6'(ld_idx);
							case (func_q)
								FN_RTX_SEQ, FN_RTX_PAIR: begin
									res_q.rtx <= rtx_cnt_q;
									rtx_cnt_q <= rtx_cnt_q + 16'd1;
								end
								FN_ACK: res_q.newly <= !seq_ent_q.acked;
								default: ;
							endcase
						end
					end
				end
				S_PUSH: begin
					if (count_q[6]) begin
						// order ram full: drop the oldest record first
						ret_q   <= S_PUSH;
						state_q <= S_POPRD;
					end else begin
						count_q <= count_q + 7'd1;
						state_q <= (mode_q == MODE_CIRC) ? S_CIRC : S_FINISH;
					end
				end
				S_CIRC: begin
					if (count_q > 7'(CIRCULAR_DEPTH)) begin
						ret_q   <= S_CIRC;
						state_q <= S_POPRD;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_TCHK: begin
					state_q <= (count_q != 7'd0) ? S_POPRD : S_FINISH;
				end
				S_POPRD: begin
					state_q <= S_POPEV;
				end
				S_POPEV: begin
					if (ret_q == S_TCHK && exp_diff[31]) begin
						state_q <= S_FINISH;
					end else begin
						head_q     <= head_q + 1'b1;
						count_q    <= count_q - 7'd1;
						key_q      <= f_rdata.seq;
						pop_q      <= 1'b1;
						rd_addr_q  <= '0;
						rd_vld_s1  <= 1'b0;
						seq_hit_q  <= 1'b0;
						pair_hit_q <= 1'b0;
						free_hit_q <= 1'b0;
						state_q    <= S_SCAN;
					end
				end
				S_FINISH: begin
					if (!out_vld_q || m_tready) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/rbi_ram.sv -----
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module rbi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench of the retransmission buffer index
`timescale 1ns / 1ps
module tb_top import rbi_pkg::*; ();

	localparam int TDEPTH = 64;
	localparam int CDEPTH = 30;

	typedef struct {
		logic [2:0]  func;
		logic [15:0] seq;
		logic [6:0]  pt;
		logic        hs;
		logic [15:0] fid;
		logic [15:0] fseq;
	} op_t;

	typedef struct {
		op_t  op;
		logic chk;
		res_t res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	retransmission_buffer_index_unit #(.TABLE_DEPTH(TDEPTH), .CIRCULAR_DEPTH(CDEPTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// model copy of the index
	entry_t      tbl [TDEPTH];
	logic [15:0] ord_sn [64];
	logic [31:0] ord_exp [64];
	int          ord_cnt, ord_head;
	logic [31:0] ticks;
	logic [15:0] rtx_ctr;
	logic [1:0]  m_mode;
	logic [6:0]  m_rtxpt;
	logic [15:0] m_hold;

	// expected results in flight
	res_t exp_q [16];
	int   exp_wr = 0, exp_rd = 0;
	row_t dir [32];
	int   n_dir = 0;
	int   errors = 0;
	int   in_gap = 0, out_stall = 0;
	bit   hold_off = 0;

	function automatic int find_seq(logic [15:0] s);
		for (int i = 0; i < TDEPTH; i++)
			if (tbl[i].valid && tbl[i].seq == s) return i;
		return -1;
	endfunction

	function automatic int find_pair(logic [15:0] f, logic [15:0] fs);
		for (int i = 0; i < TDEPTH; i++)
			if (tbl[i].valid && tbl[i].sub && tbl[i].fid == f && tbl[i].fseq == fs) return i;
		return -1;
	endfunction

	function automatic int pop_oldest();
		int i;
		if (ord_cnt == 0) return 0;
		i = find_seq(ord_sn[ord_head]);
		ord_head = (ord_head + 1) % 64;
		ord_cnt--;
		if (i < 0) return 0;
		tbl[i] = '0;
		return 1;
	endfunction

	function automatic void fill_entry(ref res_t r, input int i);
		r.seq  = tbl[i].seq;
		r.sub  = tbl[i].sub;
		r.fid  = tbl[i].sub ? tbl[i].fid : 16'd0;
		r.fseq = tbl[i].sub ? tbl[i].fseq : 16'd0;
		r.slot = i[5:0];
	endfunction

	function automatic res_t predict_index(op_t op);
		res_t r = '0;
		int   i, rm = 0, t;
		logic [31:0] d;
		case (op.func)
		FN_STORE: begin
			if (op.pt == m_rtxpt) begin
				r.status = ST_SKIPPED;
				return r;
			end
			i = find_seq(op.seq);
			if (i < 0) begin
				for (t = 0; t < TDEPTH && i < 0; t++)
					if (!tbl[t].valid) i = t;
				if (i < 0) begin
					r.status = ST_FULL;
					return r;
				end
				tbl[i] = '0;
				tbl[i].valid = 1'b1;
				tbl[i].seq = op.seq;
			end
			if (op.hs && !tbl[i].sub && find_pair(op.fid, op.fseq) < 0) begin
				tbl[i].sub = 1'b1;
				tbl[i].fid = op.fid;
				tbl[i].fseq = op.fseq;
			end
			fill_entry(r, i);
			if (m_mode == MODE_CIRC || m_mode == MODE_TIMED) begin
				if (ord_cnt >= 64) rm += pop_oldest();
				ord_sn[(ord_head + ord_cnt) % 64] = op.seq;
				ord_exp[(ord_head + ord_cnt) % 64] = ticks + {16'd0, m_hold};
				ord_cnt++;
				if (m_mode == MODE_CIRC)
					while (ord_cnt > CDEPTH) rm += pop_oldest();
			end
			r.removed = rm[6:0];
		end
		FN_RTX_SEQ, FN_RTX_PAIR: begin
			i = (op.func == FN_RTX_SEQ) ? find_seq(op.seq) : find_pair(op.fid, op.fseq);
			if (i < 0) begin
				r.status = ST_NOTFOUND;
				return r;
			end
			fill_entry(r, i);
			r.rtx = rtx_ctr;
			rtx_ctr++;
		end
		FN_ACK, FN_NACK: begin
			i = find_seq(op.seq);
			if (i < 0) begin
				r.status = ST_NOTFOUND;
				return r;
			end
			fill_entry(r, i);
			if (op.func == FN_ACK) begin
				r.newly = !tbl[i].acked;
				tbl[i].acked = 1'b1;
			end else
				tbl[i].nacked = 1'b1;
		end
		FN_TICK: begin
			ticks++;
			if (m_mode == MODE_TIMED) begin
				while (ord_cnt > 0) begin
					d = ticks - ord_exp[ord_head];
					if (d[31]) break;
					rm += pop_oldest();
				end
			end
			r.removed = rm[6:0];
		end
		FN_QUERY: begin
			i = find_pair(op.fid, op.fseq);
			if (i < 0) begin
				r.status = ST_NOTFOUND;
				return r;
			end
			fill_entry(r, i);
		end
		default: r.status = ST_NOTFOUND;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	// caller drops the write enable after its last write
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
		CFG_MODE: m_mode = val[1:0];
		CFG_RTX_PT: m_rtxpt = val[6:0];
		CFG_HOLD: m_hold = val;
		CFG_RTX_START: rtx_ctr = val;
		default: ;
		endcase
	endtask

	// offer one item, hold valid until accepted
	task automatic send_op(op_t op, logic chk, res_t want);
		res_t p;
		while (in_gap > 0 && $urandom_range(99) < in_gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {op.fseq, op.fid, op.hs, op.pt, op.seq};
		s_tuser <= op.func;
		do @(posedge clk); while (!s_tready);
		p = predict_index(op);
		if (chk && p != want) report_mismatch("directed prediction", p.status, want.status);
		exp_q[exp_wr % 16] = p;
		exp_wr++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (exp_rd != exp_wr) @(posedge clk);
		repeat (TDEPTH * 4) @(posedge clk);
	endtask

	// result side
	always @(posedge clk) begin
		res_t r, e;
		if (m_tvalid && m_tready) begin
			r = '0;
			{r.removed, r.newly, r.slot, r.rtx, r.fseq, r.fid, r.sub, r.seq} = m_tdata[78:0];
			r.status = m_tuser;
			if (exp_rd == exp_wr) report_mismatch("unexpected transfer", 0, 0);
			else begin
				e = exp_q[exp_rd % 16];
				exp_rd++;
				if (r.status != e.status) report_mismatch("status", r.status, e.status);
				if (r.seq != e.seq) report_mismatch("seq_num_out", r.seq, e.seq);
				if (r.sub != e.sub) report_mismatch("has_subflow_out", r.sub, e.sub);
				if (r.fid != e.fid) report_mismatch("flow_id_out", r.fid, e.fid);
				if (r.fseq != e.fseq) report_mismatch("flow_seq_out", r.fseq, e.fseq);
				if (r.rtx != e.rtx) report_mismatch("rtx_seq_num", r.rtx, e.rtx);
				if (r.slot != e.slot) report_mismatch("slot", r.slot, e.slot);
				if (r.newly != e.newly) report_mismatch("newly_acked", r.newly, e.newly);
				if (r.removed != e.removed) report_mismatch("removed_count", r.removed, e.removed);
			end
		end
		m_tready <= !hold_off && !(out_stall > 0 && $urandom_range(99) < out_stall);
	end

	function automatic op_t mk(logic [2:0] f, logic [15:0] s, logic [6:0] pt, logic hs,
			logic [15:0] fi, logic [15:0] fs);
		op_t o;
		o.func = f; o.seq = s; o.pt = pt; o.hs = hs; o.fid = fi; o.fseq = fs;
		return o;
	endfunction

	function automatic res_t rs(logic [1:0] st);
		res_t r = '0;
		r.status = st;
		return r;
	endfunction

	function automatic void add_row(op_t op, logic chk, res_t want);
		dir[n_dir] = '{op, chk, want};
		n_dir++;
	endfunction

	// mostly a small pool of numbers so that lookups hit
	function automatic op_t rand_op();
		op_t o;
		int k = $urandom_range(99);
		o.func = (k < 40) ? FN_STORE : (k < 95) ? 3'($urandom_range(1, 6)) : 3'd7;
		o.seq = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(80));
		o.pt = ($urandom_range(9) == 0) ? m_rtxpt : 7'($urandom);
		o.hs = 1'($urandom_range(1));
		o.fid = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
		o.fseq = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
		return o;
	endfunction

	initial begin
		res_t z;
		int   ph;
		for (int i = 0; i < TDEPTH; i++) tbl[i] = '0;
		ord_cnt = 0; ord_head = 0; ticks = 0; rtx_ctr = 0;
		m_mode = 0; m_rtxpt = 0; m_hold = 1000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		z = '0;
		// after reset: empty table, pt 0 is the retransmission type
		add_row(mk(FN_RTX_SEQ, 16'd0, 0, 0, 0, 0), 1, rs(ST_NOTFOUND));
		add_row(mk(FN_QUERY, 0, 0, 0, 16'hFFFF, 16'hFFFF), 1, rs(ST_NOTFOUND));
		add_row(mk(FN_STORE, 16'hFFFF, 0, 1, 1, 1), 1, rs(ST_SKIPPED));
		add_row(mk(3'd7, 16'hFFFF, 7'h7F, 1, 16'hFFFF, 16'hFFFF), 1, rs(ST_NOTFOUND));
		add_row(mk(FN_TICK, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(FN_STORE, 16'hFFFF, 7'h7F, 1, 16'hFFFF, 16'hFFFF), 0, z);
		add_row(mk(FN_STORE, 16'h0000, 7'h01, 1, 16'hFFFF, 16'hFFFF), 0, z);
		add_row(mk(FN_STORE, 16'h0000, 7'h01, 1, 16'h0001, 16'h0002), 0, z);
		add_row(mk(FN_STORE, 16'h1234, 7'h05, 0, 16'h0001, 16'h0002), 0, z);
		add_row(mk(FN_STORE, 16'h1234, 7'h05, 1, 16'h0001, 16'h0002), 0, z);
		add_row(mk(FN_RTX_SEQ, 16'hFFFF, 0, 0, 0, 0), 0, z);
		add_row(mk(FN_RTX_PAIR, 0, 0, 0, 16'hFFFF, 16'hFFFF), 0, z);
		add_row(mk(FN_RTX_PAIR, 0, 0, 0, 16'h0001, 16'h0002), 0, z);
		add_row(mk(FN_QUERY, 0, 0, 0, 16'h0001, 16'h0002), 0, z);
		add_row(mk(FN_ACK, 16'hFFFF, 0, 0, 0, 0), 0, z);
		add_row(mk(FN_ACK, 16'hFFFF, 0, 0, 0, 0), 0, z);
		add_row(mk(FN_NACK, 16'h0000, 0, 0, 0, 0), 0, z);
		add_row(mk(FN_NACK, 16'h5555, 0, 0, 0, 0), 1, rs(ST_NOTFOUND));
		add_row(mk(FN_ACK, 16'h5555, 0, 0, 0, 0), 1, rs(ST_NOTFOUND));
		for (int i = 0; i < n_dir; i++) send_op(dir[i].op, dir[i].chk, dir[i].res);
		drain();

		// phases: circular, timed (tiny hold, later huge), keep-until-acked (fills up), mode 3
		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
			0: begin in_gap = 0; out_stall = 0; end
			1: begin in_gap = 62; out_stall = 0; end
			2: begin in_gap = 0; out_stall = 62; end
			default: begin in_gap = 30; out_stall = 30; end
			endcase
			write_reg(CFG_MODE, 16'(ph % 4));
			write_reg(CFG_RTX_PT, (ph == 3) ? 16'h7F : 16'($urandom_range(127)));
			write_reg(CFG_HOLD, (ph == 1) ? 16'd1 : (ph == 5) ? 16'hFFFF : 16'($urandom_range(2, 20)));
			write_reg(CFG_RTX_START, (ph == 2) ? 16'hFFFE : 16'($urandom));
			cfg_we <= 1'b0;
			if (ph == 6) fork
				begin
					hold_off = 1;
					repeat (800) @(posedge clk);
					hold_off = 0;
				end
			join_none
			repeat (ph == 2 || ph == 6 ? 100 : 60) send_op(rand_op(), 0, z);
			drain();
		end
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

endmodule
